FILE: src/olrs_pkg.sv
// Package for the display row refresh scheduler.
// Holds the row count, command, status and transfer codes, and the request and result types.
// No dependencies.
package olrs_pkg;

   localparam int ROWS = 8;
   localparam int ROW_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam int CMD_BITS = 2;
   localparam int ROW_IN_BITS = 8;
   localparam int KIND_BITS = 2;
   localparam int START_ROW_BITS = 3;
   localparam int STATUS_BITS = 3;

   localparam logic [CMD_BITS-1:0] CMD_UPDATE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_POLL = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DONE = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_FREE = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_PEND_CMD = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_SEND_CMD = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_PEND_DATA = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_SEND_DATA = 3'd4;

   localparam logic [KIND_BITS-1:0] KIND_INIT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_ROW_CMD = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_ROW_DATA = 2'd2;

   typedef logic [ROW_BITS-1:0] row_idx_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]    cmd;
      logic [ROW_IN_BITS-1:0] row;
   } req_type;

   typedef struct packed {
      logic                      accepted;
      logic                      to_backlog;
      logic                      start_valid;
      logic [KIND_BITS-1:0]      start_kind;
      logic [START_ROW_BITS-1:0] start_row;
      logic                      backlog_promoted;
   } rsp_type;

endpackage

FILE: src/olrs_req_if.sv
// Request channel of the display row refresh scheduler: valid, ready and request payload.
// Depends on olrs_pkg.
interface olrs_req_if;
   logic                             valid;
   logic                             ready;
   logic [olrs_pkg::CMD_BITS-1:0]    cmd;
   logic [olrs_pkg::ROW_IN_BITS-1:0] row;

   modport source (output valid, output cmd, output row, input ready);
   modport sink (input valid, input cmd, input row, output ready);
endinterface

FILE: src/olrs_rsp_if.sv
// Result channel of the display row refresh scheduler: valid, ready and result payload.
// Depends on olrs_pkg.
interface olrs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                accepted;
   logic                                to_backlog;
   logic                                start_valid;
   logic [olrs_pkg::KIND_BITS-1:0]      start_kind;
   logic [olrs_pkg::START_ROW_BITS-1:0] start_row;
   logic                                backlog_promoted;

   modport source (output valid, output accepted, output to_backlog, output start_valid,
                   output start_kind, output start_row, output backlog_promoted,
                   input ready);
   modport sink (input valid, input accepted, input to_backlog, input start_valid,
                 input start_kind, input start_row, input backlog_promoted,
                 output ready);
endinterface

FILE: src/oled_line_refresh_scheduler_core.sv
// Top level of the display row refresh scheduler: request register, scheduler state and
// result register. Depends on olrs_pkg, olrs_req_if, olrs_rsp_if and olrs_sched.
//
// Each request (update row, poll, or transfer complete) yields exactly one result. A
// request is captured in an input register, decided against the per-row status when it
// moves on to the output register, and its result is held there until taken; one request
// is accepted every cycle while results drain.
// Throughput is set by the single read-modify-write of the row status table per cycle.
// After reset every row is marked as needing commands and the first poll starts the init
// sequence.
module oled_line_refresh_scheduler_core (
   input logic       clock,
   input logic       reset,
   olrs_req_if.sink  req_bus,
   olrs_rsp_if.source rsp_bus
);
   import olrs_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff, s1_req_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    advance;
   logic    take;
   rsp_type result;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign take = req_bus.valid && req_bus.ready;

   olrs_sched u_sched (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .req    (s1_req_ff),
      .result (result)
   );

   always_comb begin
      s1_req_in = s1_req_ff;
      if (take) begin
         s1_req_in.cmd = req_bus.cmd;
         s1_req_in.row = req_bus.row;
      end
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_in = advance ? result : rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_req_ff <= s1_req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.accepted = rsp_ff.accepted;
   assign rsp_bus.to_backlog = rsp_ff.to_backlog;
   assign rsp_bus.start_valid = rsp_ff.start_valid;
   assign rsp_bus.start_kind = rsp_ff.start_kind;
   assign rsp_bus.start_row = rsp_ff.start_row;
   assign rsp_bus.backlog_promoted = rsp_ff.backlog_promoted;

endmodule

FILE: src/olrs_sched.sv
// Scheduler state of the display row refresh scheduler: per-row status and backlog flags,
// init and busy flags, round-robin row pointer, and the decision logic for one request.
// Depends on olrs_pkg.
module olrs_sched (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  olrs_pkg::req_type req,
   output olrs_pkg::rsp_type result
);
   import olrs_pkg::*;

   logic        init_ff, init_in;
   logic        busy_ff, busy_in;
   row_idx_type cur_ff, cur_in;
   status_type  status_ff [ROWS];
   logic        backlog_ff [ROWS];

   row_idx_type addr;
   row_idx_type next_row;
   logic        row_ok;
   status_type  st_rd;
   logic        bl_rd;
   logic        st_we;
   status_type  st_wd;
   logic        bl_set;
   logic        bl_clr;

   assign row_ok = (req.row < ROW_IN_BITS'(ROWS));
   assign addr = (req.cmd == CMD_UPDATE) ? req.row[ROW_BITS-1:0] : cur_ff;
   assign st_rd = status_ff[addr];
   assign bl_rd = backlog_ff[addr];
   assign next_row = (cur_ff == ROW_BITS'(ROWS - 1)) ? '0 : cur_ff + 1'b1;

   always_comb begin
      result = '0;
      init_in = init_ff;
      busy_in = busy_ff;
      cur_in = cur_ff;
      st_we = 1'b0;
      st_wd = st_rd;
      bl_set = 1'b0;
      bl_clr = 1'b0;
      if (step) begin
         case (req.cmd)
            CMD_UPDATE: begin
               if (row_ok) begin
                  result.accepted = 1'b1;
                  if (st_rd == ST_FREE || st_rd == ST_PEND_CMD) begin
                     st_we = 1'b1;
                     st_wd = ST_PEND_CMD;
                  end else begin
                     bl_set = 1'b1;
                     result.to_backlog = 1'b1;
                  end
               end
            end
            CMD_POLL: begin
               if (!busy_ff) begin
                  if (!init_ff) begin
                     init_in = 1'b1;
                     busy_in = 1'b1;
                     result.start_valid = 1'b1;
                     result.start_kind = KIND_INIT;
                  end else begin
                     case (st_rd)
                        ST_FREE: begin
                           cur_in = next_row;
                        end
                        ST_PEND_CMD: begin
                           st_we = 1'b1;
                           st_wd = ST_SEND_CMD;
                           busy_in = 1'b1;
                           result.start_valid = 1'b1;
                           result.start_kind = KIND_ROW_CMD;
                           result.start_row = START_ROW_BITS'(cur_ff);
                        end
                        ST_PEND_DATA: begin
                           st_we = 1'b1;
                           st_wd = ST_SEND_DATA;
                           busy_in = 1'b1;
                           result.start_valid = 1'b1;
                           result.start_kind = KIND_ROW_DATA;
                           result.start_row = START_ROW_BITS'(cur_ff);
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            CMD_DONE: begin
               if (busy_ff) begin
                  if (st_rd == ST_SEND_CMD) begin
                     st_we = 1'b1;
                     st_wd = ST_PEND_DATA;
                  end else if (st_rd == ST_SEND_DATA) begin
                     st_we = 1'b1;
                     st_wd = ST_FREE;
                     if (bl_rd) begin
                        bl_clr = 1'b1;
                        result.backlog_promoted = 1'b1;
                     end
                     cur_in = next_row;
                  end
                  busy_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b0;
         busy_ff <= 1'b0;
         cur_ff <= '0;
         for (int i = 0; i < ROWS; i++) begin
            status_ff[i] <= ST_PEND_CMD;
            backlog_ff[i] <= 1'b0;
         end
      end else begin
         init_ff <= init_in;
         busy_ff <= busy_in;
         cur_ff <= cur_in;
         if (st_we) begin
            status_ff[addr] <= st_wd;
         end
         if (bl_set) begin
            backlog_ff[addr] <= 1'b1;
         end else if (bl_clr) begin
            backlog_ff[addr] <= 1'b0;
         end
      end
   end

endmodule
